### rtl/core/pft_pkg.sv
// Shared types and constants for the polygon fan triangulator.
`default_nettype none

package pft_pkg;

  // Fixed field widths
  localparam int WORD_W  = 21;   // signed index word
  localparam int VERT_W  = 20;   // vertex port width
  localparam int MODE_W  = 2;    // topology register
  localparam int ADDR_W  = 3;    // byte address of the register file
  localparam int DATA_W  = 32;

  // Topology codes
  localparam logic [MODE_W-1:0] TOPO_TRI  = 2'd0;
  localparam logic [MODE_W-1:0] TOPO_QUAD = 2'd1;
  localparam logic [MODE_W-1:0] TOPO_NGON = 2'd2;

  // Register index (word address, paddr[2])
  localparam logic REG_TOPOLOGY = 1'b0;

  // Face position: vertices seen in the open face, saturating at three
  typedef logic [1:0] face_pos_t;
  localparam face_pos_t POS_START = 2'd0;
  localparam face_pos_t POS_SECOND = 2'd1;
  localparam face_pos_t POS_THIRD = 2'd2;
  localparam face_pos_t POS_MORE  = 2'd3;

  typedef logic [VERT_W-1:0] vert_t;

  typedef struct packed {
    vert_t corner_first;
    vert_t corner_previous;
    vert_t corner_current;
    logic  face_done;
  } pft_result_t;

endpackage

`default_nettype wire

### rtl/core/pft_cfg.sv
// APB-style configuration register holding the topology mode.
`default_nettype none

module pft_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pft_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pft_pkg::DATA_W-1:0]   pwdata,
  output logic      [pft_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic      [pft_pkg::MODE_W-1:0]   topology_mode
);

  logic [pft_pkg::MODE_W-1:0] mode_r;
  logic [pft_pkg::MODE_W-1:0] mode_nxt;
  logic                       sel_topo;

  assign sel_topo = (paddr[2] == pft_pkg::REG_TOPOLOGY);
  assign pready   = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    if (psel && penable && pwrite && sel_topo) begin
      mode_nxt = pwdata[pft_pkg::MODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pft_pkg::TOPO_TRI;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_topo) begin
      prdata[pft_pkg::MODE_W-1:0] = mode_r;
    end
  end

  assign topology_mode = mode_r;

endmodule

`default_nettype wire

### rtl/core/pft_face_tracker.sv
// Face state and fan decode: apex, prior vertex and face position.
`default_nettype none

module pft_face_tracker #(
  parameter int VW = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire logic [pft_pkg::WORD_W-1:0]    index_word,
  input  wire logic                          last_of_submesh,
  input  wire logic [pft_pkg::MODE_W-1:0]    topology_mode,
  output logic                               emit,
  output pft_pkg::pft_result_t               result
);

  logic [VW-1:0]      apex_r, apex_nxt;
  logic [VW-1:0]      prior_r, prior_nxt;
  pft_pkg::face_pos_t pos_r, pos_nxt;

  logic          reserved;
  logic          end_mark;
  logic          ends;
  logic [VW-1:0] vert;

  assign reserved = (topology_mode != pft_pkg::TOPO_TRI)
                 && (topology_mode != pft_pkg::TOPO_QUAD)
                 && (topology_mode != pft_pkg::TOPO_NGON);

  // n-gon end mark: negative word carries ~vertex
  assign end_mark = (topology_mode == pft_pkg::TOPO_NGON) && index_word[pft_pkg::WORD_W-1];

  always_comb begin
    if (end_mark) begin
      vert = ~index_word[VW-1:0];
    end else begin
      vert = index_word[VW-1:0];
    end
  end

  always_comb begin
    ends = end_mark || last_of_submesh;
    if (topology_mode == pft_pkg::TOPO_TRI
        && (pos_r == pft_pkg::POS_THIRD || pos_r == pft_pkg::POS_MORE)) begin
      ends = 1'b1;
    end
    if (topology_mode == pft_pkg::TOPO_QUAD && pos_r == pft_pkg::POS_MORE) begin
      ends = 1'b1;
    end
  end

  assign emit = !reserved && (pos_r == pft_pkg::POS_THIRD || pos_r == pft_pkg::POS_MORE);

  assign result.corner_first    = pft_pkg::vert_t'(apex_r);
  assign result.corner_previous = pft_pkg::vert_t'(prior_r);
  assign result.corner_current  = pft_pkg::vert_t'(vert);
  assign result.face_done       = ends;

  always_comb begin
    apex_nxt  = apex_r;
    prior_nxt = prior_r;
    pos_nxt   = pos_r;
    if (advance) begin
      if (reserved) begin
        pos_nxt = pft_pkg::POS_START;
      end else begin
        if (pos_r == pft_pkg::POS_START) begin
          apex_nxt = vert;
        end
        prior_nxt = vert;
        if (ends) begin
          pos_nxt = pft_pkg::POS_START;
        end else if (pos_r == pft_pkg::POS_MORE) begin
          pos_nxt = pft_pkg::POS_MORE;
        end else begin
          pos_nxt = pos_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apex_r  <= '0;
      prior_r <= '0;
      pos_r   <= pft_pkg::POS_START;
    end else begin
      apex_r  <= apex_nxt;
      prior_r <= prior_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // a closed face restarts
  a_close_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && ends |=> pos_r == pft_pkg::POS_START)
    else $error("face did not restart after close");

  // reserved topology drops the open face
  a_reserved_drops: assert property (@(posedge clk) disable iff (!rst_n)
    advance && reserved |=> pos_r == pft_pkg::POS_START)
    else $error("reserved topology left a face open");

  // first vertex of a face becomes the apex
  a_apex_capture: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !reserved && pos_r == pft_pkg::POS_START |=> apex_r == $past(vert))
    else $error("apex not captured at face start");

endmodule

`default_nettype wire

### rtl/core/pft_out_reg.sv
// Result register that decouples the decode stage from the receiver.
`default_nettype none

module pft_out_reg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire pft_pkg::pft_result_t  load_data,
  input  wire logic                  out_stall,
  output logic                       free,
  output logic                       out_valid,
  output pft_pkg::pft_result_t       out_data
);

  logic                 valid_r, valid_nxt;
  pft_pkg::pft_result_t data_r, data_nxt;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = load_data;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

### rtl/core/polygon_fan_triangulator.sv
// Top level of the polygon fan triangulator.
// Usage:
//  - Input channel (in_valid / in_stall): one index word per request plus the
//    last-of-submesh flag. A request is taken when in_valid is high and
//    in_stall is low.
//  - Output channel (out_valid / out_stall): one fan triangle per request
//    (apex, previous, current, face_done). Vertices before the third of a
//    face, short faces and words under the reserved topology give nothing.
//  - Config: APB-style, one register at byte 0 (topology_mode: 0 triangles,
//    1 quads, 2 n-gons closed by a negative word). pready is tied high.
//    Write it only while the block is idle.
// Timing:
//  - Input register, decode logic, result register: a taken word is held in the
//    input register; its triangle then goes to the result register. One word
//    per cycle unless stalled, set by the single decode stage and face state.
//  - When the receiver stalls, the result register holds its triangle; the
//    next word waits in the input register and in_stall rises only when that
//    word also yields a triangle. Words yielding nothing still drain.
// Reset (rst_n, synchronous): both stages empty, face state at start of face,
// topology back to triangles.
`default_nettype none

module polygon_fan_triangulator #(
  parameter int VERTEX_INDEX_BITS = 20
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [pft_pkg::WORD_W-1:0] in_index_word,
  input  wire logic                            in_last_of_submesh,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic        [pft_pkg::VERT_W-1:0]    out_corner_first,
  output logic        [pft_pkg::VERT_W-1:0]    out_corner_previous,
  output logic        [pft_pkg::VERT_W-1:0]    out_corner_current,
  output logic                                 out_face_done,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic   [pft_pkg::ADDR_W-1:0]    paddr,
  input  wire logic   [pft_pkg::DATA_W-1:0]    pwdata,
  output logic        [pft_pkg::DATA_W-1:0]    prdata,
  output logic                                 pready
);

  // Vertex bits that survive to the 20-bit ports
  localparam int VW = (VERTEX_INDEX_BITS < pft_pkg::VERT_W) ? VERTEX_INDEX_BITS
                                                            : pft_pkg::VERT_W;

  logic [pft_pkg::MODE_W-1:0] topology_mode;

  // input register
  logic                        s1_valid_r, s1_valid_nxt;
  logic [pft_pkg::WORD_W-1:0]  s1_word_r, s1_word_nxt;
  logic                        s1_last_r, s1_last_nxt;

  logic                        s1_go;
  logic                        emit;
  logic                        out_free;
  pft_pkg::pft_result_t        result;
  pft_pkg::pft_result_t        out_data;

  pft_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .topology_mode (topology_mode)
  );

  // held word moves on unless it needs the result register and that is full
  assign s1_go    = s1_valid_r && (!emit || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_word_nxt  = s1_word_r;
    s1_last_nxt  = s1_last_r;
    if (in_valid && !in_stall) begin
      s1_valid_nxt = 1'b1;
      s1_word_nxt  = in_index_word;
      s1_last_nxt  = in_last_of_submesh;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_word_r <= s1_word_nxt;
    s1_last_r <= s1_last_nxt;
  end

  pft_face_tracker #(
    .VW (VW)
  ) u_tracker (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (s1_go),
    .index_word      (s1_word_r),
    .last_of_submesh (s1_last_r),
    .topology_mode   (topology_mode),
    .emit            (emit),
    .result          (result)
  );

  pft_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_go && emit),
    .load_data (result),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_corner_first    = out_data.corner_first;
  assign out_corner_previous = out_data.corner_previous;
  assign out_corner_current  = out_data.corner_current;
  assign out_face_done       = out_data.face_done;

  // a held word that stalls the input is only ever blocked by a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> emit && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // a word that produced a triangle shows up on the result register next cycle
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && emit |=> out_valid && out_data == $past(result))
    else $error("triangle lost on way to result register");

  // a stalled word stays in the input register
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_valid_r && $stable(s1_word_r) && $stable(s1_last_r))
    else $error("stalled word dropped");

endmodule

`default_nettype wire

### verif/polygon_fan_triangulator_tb.sv
// Self-checking testbench for the polygon fan triangulator: directed and random index streams.
`timescale 1ns / 1ps

module polygon_fan_triangulator_tb;

  // The package names three topologies; the fourth register value is reserved.
  localparam logic [pft_pkg::MODE_W-1:0] TOPO_RESERVED = 2'd3;

  // Byte addresses: the topology register and one address past the register list.
  localparam logic [pft_pkg::ADDR_W-1:0] TOPO_ADDR  = {pft_pkg::REG_TOPOLOGY, 2'b00};
  localparam logic [pft_pkg::ADDR_W-1:0] SPARE_ADDR = 3'd4;

  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 8;     // pipeline is two deep; leave margin
  localparam int IDLE_PCT       = 27;
  localparam int QUIET_FROM     = 1500;  // no idling on either side in this window
  localparam int QUIET_TO       = 2500;
  localparam int HOLD_AT        = 150;   // triangles seen before the long receiver hold
  localparam int HOLD_LEN       = 400;
  localparam int DRAIN_AT       = 1000;  // requests taken before the sender drains
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic signed [pft_pkg::WORD_W-1:0] word;
    logic                              last;
  } index_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [pft_pkg::WORD_W-1:0] in_index_word = '0;
  logic                              in_last_of_submesh = 1'b0;

  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [pft_pkg::VERT_W-1:0] out_corner_first;
  logic [pft_pkg::VERT_W-1:0] out_corner_previous;
  logic [pft_pkg::VERT_W-1:0] out_corner_current;
  logic                       out_face_done;

  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [pft_pkg::ADDR_W-1:0] paddr = '0;
  logic [pft_pkg::DATA_W-1:0] pwdata = '0;
  logic [pft_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  polygon_fan_triangulator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_index_word      (in_index_word),
    .in_last_of_submesh (in_last_of_submesh),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_corner_first   (out_corner_first),
    .out_corner_previous(out_corner_previous),
    .out_corner_current (out_corner_current),
    .out_face_done      (out_face_done),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Requests waiting to be driven, and triangles waiting to come out.
  index_req_t           index_backlog[$];
  pft_pkg::pft_result_t tri_expect[$];

  // Our own copy of the face state and the topology register.
  logic [pft_pkg::MODE_W-1:0] topo_cfg = pft_pkg::TOPO_TRI;
  pft_pkg::vert_t             apex_v = '0;
  pft_pkg::vert_t             prior_v = '0;
  pft_pkg::face_pos_t         face_at = pft_pkg::POS_START;

  int cyc_count = 0;
  int mismatches = 0;
  int words_taken = 0;
  int tris_seen = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic drain_wait = 1'b0;
  int drain_cnt = 0;

  always @(posedge clk) cyc_count <= cyc_count + 1;

  // Random idle decision shared by both sides; suppressed inside the quiet window.
  function automatic logic coin_idle();
    return (cyc_count < QUIET_FROM || cyc_count >= QUIET_TO) &&
           ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Fan split of one accepted word: updates the face state, queues a triangle if due.
  function automatic void fan_predict(input logic signed [pft_pkg::WORD_W-1:0] w,
                                      input logic last);
    pft_pkg::vert_t       v;
    logic                 closes;
    pft_pkg::pft_result_t tri_r;
    if (topo_cfg == TOPO_RESERVED) begin
      // reserved topology: word dropped, face restarts
      face_at = pft_pkg::POS_START;
      return;
    end
    if (topo_cfg == pft_pkg::TOPO_NGON && w[pft_pkg::WORD_W-1]) begin
      v      = ~w[pft_pkg::VERT_W-1:0];   // end mark carries the vertex inverted
      closes = 1'b1;
    end else begin
      v      = w[pft_pkg::VERT_W-1:0];    // negative outside n-gon mode is just a vertex
      closes = 1'b0;
    end
    if (topo_cfg == pft_pkg::TOPO_TRI && face_at >= pft_pkg::POS_THIRD) closes = 1'b1;
    if (topo_cfg == pft_pkg::TOPO_QUAD && face_at == pft_pkg::POS_MORE) closes = 1'b1;
    if (last) closes = 1'b1;
    if (face_at == pft_pkg::POS_START) begin
      apex_v = v;
    end else if (face_at >= pft_pkg::POS_THIRD) begin
      tri_r = '{corner_first: apex_v, corner_previous: prior_v,
                corner_current: v, face_done: closes};
      tri_expect.push_back(tri_r);
    end
    prior_v = v;
    if (closes) face_at = pft_pkg::POS_START;
    else if (face_at != pft_pkg::POS_MORE) face_at = face_at + 1'b1;
  endfunction

  function automatic void queue_word(input logic signed [pft_pkg::WORD_W-1:0] w,
                                     input logic last);
    index_req_t r;
    r.word = w;
    r.last = last;
    index_backlog.push_back(r);
  endfunction

  // n-gon end mark for vertex v
  function automatic logic signed [pft_pkg::WORD_W-1:0] end_mark(input pft_pkg::vert_t v);
    return {1'b1, ~v};
  endfunction

  // Vertex values biased toward the extremes.
  function automatic pft_pkg::vert_t rand_vert();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return pft_pkg::vert_t'($urandom_range(15));
      default: return pft_pkg::vert_t'($urandom());
    endcase
  endfunction

  function automatic logic signed [pft_pkg::WORD_W-1:0] rand_word();
    return {1'($urandom_range(1)), rand_vert()};
  endfunction

  // Random stream for one topology: mostly well-formed faces, some noise.
  function automatic void random_phase(input logic [pft_pkg::MODE_W-1:0] mode,
                                       input int n_items);
    int count;
    int len;
    int sel;
    int k;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(99) < 75) begin
        sel = $urandom_range(99);
        if (mode == pft_pkg::TOPO_NGON) begin
          len = (sel < 10) ? $urandom_range(1, 2) :
                (sel < 90) ? $urandom_range(3, 8) : $urandom_range(9, 24);
          for (k = 0; k < len - 1; k++) queue_word({1'b0, rand_vert()}, 1'b0);
          // close mostly by end mark, sometimes by the last-of-submesh flag
          if ($urandom_range(99) < 85) queue_word(end_mark(rand_vert()), 1'b0);
          else queue_word({1'b0, rand_vert()}, 1'b1);
        end else begin
          len = (mode == pft_pkg::TOPO_QUAD) ? 4 : 3;
          if (sel < 10) begin
            len = $urandom_range(1, 2);   // short face cut by the flag
            for (k = 0; k < len - 1; k++) queue_word(rand_word(), 1'b0);
            queue_word(rand_word(), 1'b1);
          end else begin
            for (k = 0; k < len - 1; k++) queue_word(rand_word(), 1'b0);
            queue_word(rand_word(), 1'($urandom_range(99) < 10));
          end
        end
        count += len;
      end else begin
        queue_word(rand_word(), 1'($urandom_range(99) < 10));
        count++;
      end
    end
  endfunction

  // Wait until nothing is pending or in flight, then let the pipeline empty.
  task automatic wait_quiet();
    @(negedge clk);
    while (index_backlog.size() != 0 || in_valid || drain_wait || tri_expect.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write followed by a read-back; the topology register must read what was written.
  task automatic apb_write_check(input logic [pft_pkg::ADDR_W-1:0] addr,
                                 input logic [pft_pkg::DATA_W-1:0] data);
    logic [pft_pkg::DATA_W-1:0] want;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // write lands at this edge
    if (addr == TOPO_ADDR) topo_cfg = data[pft_pkg::MODE_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = {{(pft_pkg::DATA_W-pft_pkg::MODE_W){1'b0}}, topo_cfg};
    if (addr == TOPO_ADDR && prdata !== want) begin
      $display("%0t: topology read-back expected %h got %h", $time, want, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Driver: holds a stalled request, otherwise offers the next backlog entry or idles.
  always @(posedge clk) begin : drive_proc
    index_req_t nxt;
    logic       held;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      held = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        fan_predict(in_index_word, in_last_of_submesh);
        words_taken++;
        if (words_taken == DRAIN_AT) begin
          // pause the sender until every triangle owed has come out
          drain_wait = 1'b1;
          drain_cnt  = SETTLE_CYCLES;
        end
      end
      if (drain_wait) begin
        if (drain_cnt > 0) drain_cnt--;
        else if (tri_expect.size() == 0) drain_wait = 1'b0;
      end
      if (!held) begin
        if (index_backlog.size() != 0 && !drain_wait && !coin_idle()) begin
          nxt = index_backlog.pop_front();
          in_valid           <= 1'b1;
          in_index_word      <= nxt.word;
          in_last_of_submesh <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each triangle against the oldest expectation; drives out_stall.
  always @(posedge clk) begin : monitor_proc
    pft_pkg::pft_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        tris_seen++;
        if (tri_expect.size() == 0) begin
          $display("%0t: unexpected triangle got %h %h %h %b", $time, out_corner_first,
                   out_corner_previous, out_corner_current, out_face_done);
          mismatches++;
        end else begin
          want = tri_expect.pop_front();
          if (out_corner_first !== want.corner_first) begin
            $display("%0t: corner_first expected %h got %h", $time,
                     want.corner_first, out_corner_first);
            mismatches++;
          end
          if (out_corner_previous !== want.corner_previous) begin
            $display("%0t: corner_previous expected %h got %h", $time,
                     want.corner_previous, out_corner_previous);
            mismatches++;
          end
          if (out_corner_current !== want.corner_current) begin
            $display("%0t: corner_current expected %h got %h", $time,
                     want.corner_current, out_corner_current);
            mismatches++;
          end
          if (out_face_done !== want.face_done) begin
            $display("%0t: face_done expected %b got %b", $time,
                     want.face_done, out_face_done);
            mismatches++;
          end
        end
      end
      // one long hold while the backlog is deep, so the block fills and stalls its input
      if (!hold_done && tris_seen >= HOLD_AT && index_backlog.size() > 40) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= coin_idle();
      end
    end
  end

  // Watchdog: too long without any request or triangle moving ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [pft_pkg::MODE_W-1:0] plan_mode [8];
    int                         plan_len  [8];
    int                         p;
    plan_mode = '{pft_pkg::TOPO_NGON, pft_pkg::TOPO_TRI, pft_pkg::TOPO_QUAD, TOPO_RESERVED,
                  pft_pkg::TOPO_NGON, pft_pkg::TOPO_QUAD, pft_pkg::TOPO_TRI,
                  pft_pkg::TOPO_NGON};
    plan_len  = '{400, 250, 250, 30, 300, 100, 100, 100};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Triangles at reset topology; negative words are plain vertices here.
    queue_word(21'sh100000, 1'b0);
    queue_word(21'sh1FFFFF, 1'b0);
    queue_word(21'sh0FFFFF, 1'b0);
    // short face cut by last-of-submesh
    queue_word(21'sd7, 1'b0);
    queue_word(21'sd8, 1'b1);
    wait_quiet();

    apb_write_check(TOPO_ADDR, {30'h2AAAAAAA, pft_pkg::TOPO_QUAD});
    queue_word(21'sd1, 1'b0);
    queue_word(21'sd2, 1'b0);
    queue_word(21'sd3, 1'b0);
    queue_word(21'sd4, 1'b0);
    // quad closed early by the flag after three vertices
    queue_word(21'sd5, 1'b0);
    queue_word(21'sd6, 1'b0);
    queue_word(21'sd7, 1'b1);
    wait_quiet();

    apb_write_check(TOPO_ADDR, {30'h15555555, pft_pkg::TOPO_NGON});
    queue_word(21'sd10, 1'b0);
    queue_word(21'sd11, 1'b0);
    queue_word(21'sd12, 1'b0);
    queue_word(21'sd13, 1'b0);
    queue_word(end_mark(20'd14), 1'b0);
    // lone end mark: one-vertex face
    queue_word(end_mark(20'd20), 1'b0);
    // leave a face open, then switch to triangles: next word closes it
    queue_word(21'sd30, 1'b0);
    queue_word(21'sd31, 1'b0);
    queue_word(21'sd32, 1'b0);
    wait_quiet();
    apb_write_check(TOPO_ADDR, {30'h0, pft_pkg::TOPO_TRI});
    queue_word(21'sd33, 1'b0);
    wait_quiet();

    // reserved topology drops the word and restarts the open face
    apb_write_check(TOPO_ADDR, {30'h0, pft_pkg::TOPO_NGON});
    queue_word(21'sd60, 1'b0);
    queue_word(21'sd61, 1'b0);
    wait_quiet();
    apb_write_check(TOPO_ADDR, {30'h3FFFFFFF, TOPO_RESERVED});
    queue_word(21'sd62, 1'b0);
    wait_quiet();
    apb_write_check(TOPO_ADDR, {30'h0, pft_pkg::TOPO_NGON});
    // write past the register list must leave the topology alone
    apb_write_check(SPARE_ADDR, 32'hFFFFFFFF);
    queue_word(21'sd63, 1'b0);
    queue_word(21'sd64, 1'b0);
    queue_word(end_mark(20'd65), 1'b0);
    wait_quiet();

    // Random phases, each under its own topology.
    for (p = 0; p < 8; p++) begin
      apb_write_check(TOPO_ADDR, ($urandom() & ~32'h3) | {30'h0, plan_mode[p]});
      if ($urandom_range(1)) apb_write_check(SPARE_ADDR, $urandom());
      random_phase(plan_mode[p], plan_len[p]);
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/pft_pkg.sv
rtl/core/pft_cfg.sv
rtl/core/pft_face_tracker.sv
rtl/core/pft_out_reg.sv
rtl/core/polygon_fan_triangulator.sv
verif/polygon_fan_triangulator_tb.sv
